### design/bzc_pkg.sv
// Shared types, constants and lookup tables for the back-EMF zero-cross commutator.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package bzc_pkg;

  // Sizes.
  localparam int ADC_BITS   = 12;
  localparam int AVG_LEN    = 8;
  localparam int AVG_BITS   = (AVG_LEN > 1) ? $clog2(AVG_LEN) : 1;
  localparam int TICK_BITS  = 16;
  localparam int SUM_BITS   = TICK_BITS + $clog2(AVG_LEN);
  localparam int DIV_BITS   = 32;
  localparam int DCNT_BITS  = $clog2(DIV_BITS + 1);
  localparam int SC_BITS    = 8;
  localparam int PHASE_BITS = 3;
  localparam int HIST_BITS  = 6;
  localparam int STALL_BITS = 6;
  localparam int CFG_AW     = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    CFG_BLANKING = 2'd0,
    CFG_REVERSE  = 2'd1,
    CFG_SPEED    = 2'd2
  } cfg_idx_t;

  // Reset values and limits.
  localparam logic [SC_BITS-1:0]     BLANK_RST    = 8'd1;
  localparam logic [DIV_BITS-1:0]    SPEED_RST    = 32'd4000000;
  localparam logic [SC_BITS-1:0]     SC_MAX       = 8'hFF;
  localparam logic [SC_BITS-1:0]     FAST_SAMPLES = 8'd6;
  localparam logic [STALL_BITS-1:0]  STALL_LIMIT  = 6'd50;
  localparam logic [TICK_BITS-2:0]   DELAY_OFFSET = 15'd100;
  localparam logic [TICK_BITS-1:0]   DELAY_TOP    = 16'hFFFF;
  localparam logic [PHASE_BITS-1:0]  PHASE_FIRST  = 3'd1;
  localparam logic [PHASE_BITS-1:0]  PHASE_LAST   = 3'd6;

  // Expected-edge tables, indexed by {reverse_dir, phase}.
  localparam logic [2:0] EDGE_MASK [16] = '{
    3'h0, 3'h4, 3'h2, 3'h1, 3'h4, 3'h2, 3'h1, 3'h0,
    3'h0, 3'h4, 3'h1, 3'h2, 3'h4, 3'h1, 3'h2, 3'h0};
  localparam logic EDGE_INV [16] = '{
    1'b0, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0,
    1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};

  // Majority filter: next history for each history word with the new bit in bit 0.
  localparam logic [HIST_BITS-1:0] MAJ_ROM [64] = '{
    6'h00, 6'h02, 6'h04, 6'h06, 6'h08, 6'h0A, 6'h0C, 6'h0E,
    6'h10, 6'h12, 6'h14, 6'h16, 6'h18, 6'h1A, 6'h1C, 6'h1E,
    6'h20, 6'h22, 6'h24, 6'h26, 6'h28, 6'h2A, 6'h2C, 6'h2E,
    6'h01, 6'h01, 6'h01, 6'h36, 6'h01, 6'h3A, 6'h3C, 6'h3E,
    6'h00, 6'h02, 6'h04, 6'h06, 6'h08, 6'h0A, 6'h0C, 6'h0E,
    6'h01, 6'h01, 6'h01, 6'h16, 6'h01, 6'h1A, 6'h1C, 6'h1E,
    6'h01, 6'h01, 6'h01, 6'h26, 6'h01, 6'h2A, 6'h2C, 6'h2E,
    6'h01, 6'h01, 6'h01, 6'h36, 6'h01, 6'h3A, 6'h3C, 6'h3E};

  // Request to and response from the shared divider.
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] num;
    logic [DIV_BITS-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DIV_BITS-1:0] quot;
  } div_rsp_t;

endpackage

### design/bzc_if.sv
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on bzc_pkg for field widths.
`timescale 1ns / 1ps

interface bzc_in_if import bzc_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [ADC_BITS-1:0]   u_sample;
  logic [ADC_BITS-1:0]   v_sample;
  logic [ADC_BITS-1:0]   w_sample;
  logic [TICK_BITS-1:0]  elapsed_ticks;
  logic                  running;

  modport source (output valid, u_sample, v_sample, w_sample, elapsed_ticks, running,
                  input ready);
  modport sink   (input valid, u_sample, v_sample, w_sample, elapsed_ticks, running,
                  output ready);
endinterface

interface bzc_out_if import bzc_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic                   commutate;
  logic [PHASE_BITS-1:0]  phase_now;
  logic [TICK_BITS-1:0]   delay_reload;
  logic [TICK_BITS-1:0]   avg_ticks;
  logic [DIV_BITS-1:0]    speed_value;
  logic                   stall_shutdown;

  modport source (output valid, commutate, phase_now, delay_reload, avg_ticks, speed_value,
                  stall_shutdown, input ready);
  modport sink   (input valid, commutate, phase_now, delay_reload, avg_ticks, speed_value,
                  stall_shutdown, output ready);
endinterface

### design/bzc_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bzc_pkg; the caller never issues a zero divisor.
`timescale 1ns / 1ps

module bzc_div import bzc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [DIV_BITS-1:0]  rem_r;
  logic [DIV_BITS-1:0]  quo_r;
  logic [DIV_BITS-1:0]  den_r;
  logic [DCNT_BITS-1:0] cnt_r;
  logic                 busy_r;
  logic                 done_r;
  logic [DIV_BITS:0]    rem_sh;
  logic [DIV_BITS:0]    diff;

  // Trial subtraction of the divisor from the shifted partial remainder.
  always_comb begin
    rem_sh = {rem_r, quo_r[DIV_BITS-1]};
    diff   = rem_sh - {1'b0, den_r};
  end

  // Control counts the iterations; the datapath shifts the dividend out and the quotient in.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= DCNT_BITS'(DIV_BITS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_BITS'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= '0;
      quo_r <= req.num;
      den_r <= req.den;
    end else if (busy_r) begin
      if (diff[DIV_BITS]) begin
        rem_r <= rem_sh[DIV_BITS-1:0];
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b0};
      end else begin
        rem_r <= diff[DIV_BITS-1:0];
        quo_r <= {quo_r[DIV_BITS-2:0], 1'b1};
      end
    end
  end

  assign rsp.busy = busy_r;
  assign rsp.done = done_r;
  assign rsp.quot = quo_r;

endmodule

### design/bzc_edge.sv
// Zero-cross classifier: compares each phase with the three-phase average,
// selects the expected edge and steps the majority filter. Depends on bzc_pkg.
`timescale 1ns / 1ps

module bzc_edge import bzc_pkg::*; (
  input  logic [ADC_BITS-1:0]   u_sample,
  input  logic [ADC_BITS-1:0]   v_sample,
  input  logic [ADC_BITS-1:0]   w_sample,
  input  logic [PHASE_BITS-1:0] phase,
  input  logic                  reverse_dir,
  input  logic [HIST_BITS-1:0]  hist,
  output logic [HIST_BITS-1:0]  hist_nxt
);

  localparam int SW = ADC_BITS + 2;

  logic [SW-1:0] sum;
  logic [SW-1:0] u3;
  logic [SW-1:0] v3;
  logic [SW-1:0] w3;
  logic [2:0]    st;
  logic [3:0]    idx;
  logic          hit;

  // A phase lies above floor(sum/3) exactly when three times its value exceeds the sum.
  always_comb begin
    sum = SW'(u_sample) + SW'(v_sample) + SW'(w_sample);
    u3  = SW'(u_sample) + {1'b0, u_sample, 1'b0};
    v3  = SW'(v_sample) + {1'b0, v_sample, 1'b0};
    w3  = SW'(w_sample) + {1'b0, w_sample, 1'b0};
    st  = {w3 > sum, v3 > sum, u3 > sum};
  end

  // Pick the expected edge for this step and feed it to the majority filter.
  always_comb begin
    idx      = {reverse_dir, phase};
    hit      = |((st ^ {3{EDGE_INV[idx]}}) & EDGE_MASK[idx]);
    hist_nxt = MAJ_ROM[{hist[HIST_BITS-1:1], hist[0] | hit}];
  end

endmodule

### design/bemf_zero_cross_commutator_top.sv
// A sample accepted in S_IDLE passes through S_EVAL and, on a crossing with a nonzero speed
// divisor, through S_SPD while the shared divider runs; it then waits in S_DONE until the
// output register is free. A new sample is taken only after the last result has been loaded
// into the output register. The window average is a shift of the closing sum, not a division.
// Synchronous active-low reset restores phase 1, clears all history and held results and
// loads the register defaults; no clearing pass is needed.
`timescale 1ns / 1ps

module bemf_zero_cross_commutator_top import bzc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  bzc_in_if.sink            in_ch,
  bzc_out_if.source         out_ch,
  input  logic              cfg_we,
  input  logic [CFG_AW-1:0] cfg_addr,
  input  logic [DIV_BITS-1:0] cfg_wdata
);

  typedef enum logic [1:0] {S_IDLE, S_EVAL, S_SPD, S_DONE} state_t;

  state_t                 state_r;

  // Configuration registers.
  logic [SC_BITS-1:0]     blank_r;
  logic                   reverse_r;
  logic [DIV_BITS-1:0]    speed_factor_r;

  // Latched sample.
  logic [ADC_BITS-1:0]    u_r;
  logic [ADC_BITS-1:0]    v_r;
  logic [ADC_BITS-1:0]    w_r;
  logic [TICK_BITS-1:0]   ticks_r;
  logic                   running_r;

  // Commutation state.
  logic [PHASE_BITS-1:0]  phase_r;
  logic [SC_BITS-1:0]     sample_count_r;
  logic [HIST_BITS-1:0]   hist_r;
  logic [STALL_BITS-1:0]  stall_r;
  logic [SUM_BITS-1:0]    isum_r;
  logic [AVG_BITS-1:0]    icnt_r;
  logic [TICK_BITS-1:0]   avg_r;
  logic [TICK_BITS-1:0]   held_avg_r;
  logic [DIV_BITS-1:0]    held_speed_r;
  logic                   com_r;
  logic [TICK_BITS-1:0]   delay_r;

  // Output register.
  logic                   out_valid_r;
  logic                   out_com_r;
  logic [PHASE_BITS-1:0]  out_phase_r;
  logic [TICK_BITS-1:0]   out_delay_r;
  logic [TICK_BITS-1:0]   out_avg_r;
  logic [DIV_BITS-1:0]    out_speed_r;
  logic                   out_stall_r;

  logic [HIST_BITS-1:0]   hist_nxt;
  logic [SC_BITS-1:0]     sc_inc;
  logic                   detect;
  logic                   crossing;
  logic [TICK_BITS-2:0]   half;
  logic [TICK_BITS-1:0]   delay_nxt;
  logic [SUM_BITS-1:0]    sum_nxt;
  logic                   roll;
  logic [TICK_BITS-1:0]   avg_cand;
  logic [TICK_BITS-1:0]   divisor;
  logic                   spd_start;
  logic [STALL_BITS-1:0]  stall_nxt;
  logic [PHASE_BITS-1:0]  phase_nxt;
  div_req_t               div_req;
  div_rsp_t               div_rsp;

  bzc_edge u_edge (
    .u_sample    (u_r),
    .v_sample    (v_r),
    .w_sample    (w_r),
    .phase       (phase_r),
    .reverse_dir (reverse_r),
    .hist        (hist_r),
    .hist_nxt    (hist_nxt)
  );

  bzc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Crossing bookkeeping: delay reload, stall count, interval sum and next phase.
  always_comb begin
    sc_inc    = (sample_count_r != SC_MAX) ? sample_count_r + 1'b1 : sample_count_r;
    detect    = sample_count_r >= blank_r;
    crossing  = detect && hist_nxt[0];
    half      = ticks_r[TICK_BITS-1:1];
    delay_nxt = DELAY_TOP - {1'b0, (half > DELAY_OFFSET) ? half - DELAY_OFFSET : '0};
    sum_nxt   = isum_r + SUM_BITS'(ticks_r);
    roll      = icnt_r == AVG_BITS'(AVG_LEN - 1);
    phase_nxt = (phase_r >= PHASE_LAST) ? PHASE_FIRST : phase_r + 1'b1;
    if (sample_count_r <= FAST_SAMPLES && running_r) begin
      stall_nxt = (stall_r < STALL_LIMIT) ? stall_r + 1'b1 : stall_r;
    end else begin
      stall_nxt = '0;
    end
  end

  // The window average is a shift of the closing sum; the speed division uses the divider.
  always_comb begin
    avg_cand      = roll ? TICK_BITS'(sum_nxt / SUM_BITS'(AVG_LEN)) : avg_r;
    divisor       = (avg_cand != '0) ? avg_cand : ticks_r;
    spd_start     = (state_r == S_EVAL) && crossing && (divisor != '0);
    div_req.start = spd_start;
    div_req.num   = speed_factor_r;
    div_req.den   = DIV_BITS'(divisor);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blank_r        <= BLANK_RST;
      reverse_r      <= 1'b0;
      speed_factor_r <= SPEED_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_BLANKING: blank_r        <= cfg_wdata[SC_BITS-1:0];
        CFG_REVERSE:  reverse_r      <= cfg_wdata[0];
        CFG_SPEED:    speed_factor_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Sample latch.
  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      u_r       <= in_ch.u_sample;
      v_r       <= in_ch.v_sample;
      w_r       <= in_ch.w_sample;
      ticks_r   <= in_ch.elapsed_ticks;
      running_r <= in_ch.running;
    end
  end

  // Sequencer with commutation state and the output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      phase_r        <= PHASE_FIRST;
      sample_count_r <= '0;
      hist_r         <= '0;
      stall_r        <= '0;
      isum_r         <= '0;
      icnt_r         <= '0;
      avg_r          <= '0;
      held_avg_r     <= '0;
      held_speed_r   <= '0;
      com_r          <= 1'b0;
      delay_r        <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      // A taken result clears the output unless a new one is loaded in the same cycle.
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_ch.valid) begin
            sample_count_r <= sc_inc;
            state_r        <= S_EVAL;
          end
        end
        S_EVAL: begin
          if (crossing) begin
            phase_r        <= phase_nxt;
            stall_r        <= stall_nxt;
            sample_count_r <= '0;
            hist_r         <= '0;
            com_r          <= 1'b1;
            delay_r        <= delay_nxt;
            if (roll) begin
              icnt_r <= '0;
              isum_r <= '0;
              avg_r  <= avg_cand;
            end else begin
              icnt_r <= icnt_r + 1'b1;
              isum_r <= sum_nxt;
            end
            if (divisor == '0) begin
              held_speed_r <= '1;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_SPD;
            end
          end else begin
            com_r   <= 1'b0;
            delay_r <= '0;
            state_r <= S_DONE;
            if (detect) begin
              hist_r <= hist_nxt;
            end
          end
        end
        S_SPD: begin
          if (div_rsp.done) begin
            held_speed_r <= div_rsp.quot;
            state_r      <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_com_r   <= com_r;
            out_phase_r <= phase_r;
            out_delay_r <= delay_r;
            out_avg_r   <= com_r ? avg_r : held_avg_r;
            out_speed_r <= held_speed_r;
            out_stall_r <= stall_r >= STALL_LIMIT;
            if (com_r) begin
              held_avg_r <= avg_r;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ch.ready           = state_r == S_IDLE;
  assign out_ch.valid          = out_valid_r;
  assign out_ch.commutate      = out_com_r;
  assign out_ch.phase_now      = out_phase_r;
  assign out_ch.delay_reload   = out_delay_r;
  assign out_ch.avg_ticks      = out_avg_r;
  assign out_ch.speed_value    = out_speed_r;
  assign out_ch.stall_shutdown = out_stall_r;

  // The commutation step always stays within one to six.
  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r >= PHASE_FIRST && phase_r <= PHASE_LAST)
    else $error("commutation phase left its range");

  // The stall counter saturates at its limit.
  a_stall_sat: assert property (@(posedge clk) disable iff (!rst_n)
    stall_r <= STALL_LIMIT)
    else $error("stall count above limit");

  // A new transaction is only taken while the shared divider is free.
  a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !div_rsp.busy)
    else $error("input ready while divider busy");

  // A result without a commutation carries a zero delay reload.
  a_nocom_delay: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.commutate) |-> (out_ch.delay_reload == '0))
    else $error("delay reload set without commutation");

endmodule

### bench/tb_bemf_zero_cross_commutator_top.sv
// Self-checking bench for the back-EMF zero-cross commutator: it steers sample sets toward
// qualified crossings, predicts every result in its own model and compares each transaction.
// Depends on bzc_pkg, bzc_in_if/bzc_out_if and bemf_zero_cross_commutator_top.
`timescale 1ns / 1ps

module tb_bemf_zero_cross_commutator_top;
  import bzc_pkg::*;

  localparam int STALL_CAP     = 50;
  localparam int FAST_COUNT    = 6;
  localparam int DELAY_TRIM    = 100;
  localparam int SETTLE_CYCLES = 80;
  localparam int HOLD_CYCLES   = 400;
  localparam int CYCLE_LIMIT   = 1000000;

  // One sample set as it travels on the input channel.
  typedef struct packed {
    logic [ADC_BITS-1:0]  u;
    logic [ADC_BITS-1:0]  v;
    logic [ADC_BITS-1:0]  w;
    logic [TICK_BITS-1:0] ticks;
    logic                 run;
  } sample_set_t;

  // One commutation result as it leaves on the output channel.
  typedef struct packed {
    logic                  commutate;
    logic [PHASE_BITS-1:0] phase;
    logic [TICK_BITS-1:0]  delay;
    logic [TICK_BITS-1:0]  avg;
    logic [DIV_BITS-1:0]   speed;
    logic                  shutdown;
  } commutation_t;

  // Rotor tracking state of the commutator.
  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic [SC_BITS-1:0]    samples;
    logic [HIST_BITS-1:0]  hist;
    logic [STALL_BITS-1:0] stalls;
    logic [SUM_BITS-1:0]   isum;
    logic [3:0]            icount;
    logic [TICK_BITS-1:0]  avg;
    logic [TICK_BITS-1:0]  held_avg;
    logic [DIV_BITS-1:0]   held_speed;
  } rotor_state_t;

  typedef struct packed {
    logic [SC_BITS-1:0]  blank;
    logic                rev;
    logic [DIV_BITS-1:0] speed;
  } drive_regs_t;

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CFG_AW-1:0]   cfg_addr;
  logic [DIV_BITS-1:0] cfg_wdata;

  bzc_in_if  in_ch ();
  bzc_out_if out_ch ();

  bemf_zero_cross_commutator_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  sample_set_t  queued_samples[$];
  commutation_t awaited_results[$];
  rotor_state_t rotor_model;
  rotor_state_t rotor_plan;
  drive_regs_t  regs_now;
  int           samples_offered = 0;
  int           samples_taken = 0;
  int           gap_pct = 0;
  int           stall_pct = 0;
  bit           press_on = 1'b0;
  bit           press_done = 1'b0;
  int           hold_left = 0;
  int           cycle_count = 0;
  int           mismatches = 0;
  int           planned = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic rotor_state_t rotor_after_reset();
    rotor_state_t s;
    s = '0;
    s.phase = 3'd1;
    return s;
  endfunction

  // Polarity of the edge watched in the current step: each phase is compared with
  // the mean of all three, and one comparison, possibly inverted, is the edge.
  function automatic logic edge_seen(logic [PHASE_BITS-1:0] phase, logic rev, sample_set_t x);
    logic [ADC_BITS+1:0] total;
    logic [ADC_BITS+1:0] mid;
    logic [2:0]          above;
    total = x.u + x.v + x.w;
    mid = total / 3;
    above = {x.w > mid, x.v > mid, x.u > mid};
    case ({rev, phase})
      4'b0_001: return above[2];
      4'b0_010: return !above[1];
      4'b0_011: return above[0];
      4'b0_100: return !above[2];
      4'b0_101: return above[1];
      4'b0_110: return !above[0];
      4'b1_001: return !above[2];
      4'b1_010: return above[0];
      4'b1_011: return !above[1];
      4'b1_100: return above[2];
      4'b1_101: return !above[0];
      4'b1_110: return above[1];
      default:  return 1'b0;
    endcase
  endfunction

  // Majority filter: a crossing is confirmed when at least two of the three older
  // history bits are set and at most one of the three newer ones; otherwise shift.
  function automatic logic [HIST_BITS-1:0] filter_step(logic [HIST_BITS-1:0] word);
    int older;
    int newer;
    older = int'(word[5]) + int'(word[4]) + int'(word[3]);
    newer = int'(word[2]) + int'(word[1]) + int'(word[0]);
    if (older >= 2 && newer <= 1) return 6'd1;
    return {word[4:0], 1'b0};
  endfunction

  // Advances the rotor state by one sample set and returns the result it yields.
  function automatic commutation_t predict_sample(inout rotor_state_t s, input drive_regs_t c,
                                                  input sample_set_t x);
    commutation_t         r;
    logic [TICK_BITS-1:0] half;
    logic [TICK_BITS-1:0] trim;
    logic [DIV_BITS-1:0]  den;
    r = '0;
    if (s.samples != 8'hFF) s.samples = s.samples + 8'd1;
    if (s.samples >= c.blank) begin
      s.hist = filter_step({s.hist[5:1], s.hist[0] | edge_seen(s.phase, c.rev, x)});
      if (s.hist[0]) begin
        s.phase = (s.phase >= 3'd6) ? 3'd1 : s.phase + 3'd1;
        // Fast crossings while running count toward a stall shutdown.
        if (s.samples <= FAST_COUNT && x.run) begin
          if (s.stalls < STALL_CAP) s.stalls = s.stalls + 6'd1;
        end else begin
          s.stalls = '0;
        end
        half = x.ticks >> 1;
        trim = (half > DELAY_TRIM) ? half - 16'(DELAY_TRIM) : 16'd0;
        r.delay = 16'hFFFF - trim;
        r.commutate = 1'b1;
        s.samples = '0;
        s.hist = '0;
        // Interval averaging window and the speed division.
        s.isum = s.isum + x.ticks;
        s.icount = s.icount + 4'd1;
        if (s.icount >= AVG_LEN) begin
          s.icount = '0;
          s.avg = 16'(s.isum / AVG_LEN);
          s.isum = '0;
        end
        den = (s.avg != 0) ? {16'd0, s.avg} : {16'd0, x.ticks};
        s.held_avg = s.avg;
        s.held_speed = (den != 0) ? c.speed / den : '1;
      end
    end
    r.phase = s.phase;
    r.avg = s.held_avg;
    r.speed = s.held_speed;
    r.shutdown = (s.stalls >= STALL_CAP);
    return r;
  endfunction

  task automatic compare_field(string field, logic [DIV_BITS-1:0] want, logic [DIV_BITS-1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", field, want, got);
      mismatches++;
    end
  endtask

  // Input transaction driver: holds each item until it is taken.
  always @(negedge clk) begin
    sample_set_t nxt;
    if (samples_offered == samples_taken) begin
      if (queued_samples.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
        nxt = queued_samples.pop_front();
        in_ch.valid         <= 1'b1;
        in_ch.u_sample      <= nxt.u;
        in_ch.v_sample      <= nxt.v;
        in_ch.w_sample      <= nxt.w;
        in_ch.elapsed_ticks <= nxt.ticks;
        in_ch.running       <= nxt.run;
        samples_offered++;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result receiver: random stalls, plus one long hold-off to back the block up.
  always @(negedge clk) begin
    if (press_on && !press_done) begin
      hold_left = HOLD_CYCLES;
      press_done = 1'b1;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predicts on every accepted sample, checks every accepted result.
  always @(posedge clk) begin
    sample_set_t  taken;
    commutation_t want;
    if (in_ch.valid === 1'b1 && in_ch.ready === 1'b1) begin
      taken = '{u: in_ch.u_sample, v: in_ch.v_sample, w: in_ch.w_sample,
                ticks: in_ch.elapsed_ticks, run: in_ch.running};
      awaited_results.push_back(predict_sample(rotor_model, regs_now, taken));
      samples_taken++;
    end
    if (out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      if (awaited_results.size() == 0) begin
        $error("result transaction arrived with no prediction pending");
        mismatches++;
      end else begin
        want = awaited_results.pop_front();
        compare_field("commutate", want.commutate, out_ch.commutate);
        compare_field("phase_now", want.phase, out_ch.phase_now);
        compare_field("delay_reload", want.delay, out_ch.delay_reload);
        compare_field("avg_ticks", want.avg, out_ch.avg_ticks);
        compare_field("speed_value", want.speed, out_ch.speed_value);
        compare_field("stall_shutdown", want.shutdown, out_ch.stall_shutdown);
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[bemf_zero_cross_commutator_top] ERROR");
      $finish;
    end
  end

  function automatic logic [TICK_BITS-1:0] pick_ticks();
    case ($urandom_range(0, 9))
      0:       return 16'($urandom_range(0, 400));
      1:       return $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic sample_set_t noise_sample();
    sample_set_t x;
    x.u = 12'($urandom_range(0, 4095));
    x.v = 12'($urandom_range(0, 4095));
    x.w = 12'($urandom_range(0, 4095));
    x.ticks = pick_ticks();
    x.run = 1'($urandom_range(0, 1));
    return x;
  endfunction

  // Builds a sample set whose watched edge, at the planned phase, has the wanted value.
  function automatic sample_set_t shape_sample(logic want, logic [TICK_BITS-1:0] ticks,
                                               logic run);
    sample_set_t x;
    int          pick;
    logic        hi;
    x.ticks = ticks;
    x.run = run;
    do begin
      pick = $urandom_range(0, 2);
      hi = 1'($urandom_range(0, 1));
      x.u = ((pick == 0) ~^ hi) ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(0, 1000));
      x.v = ((pick == 1) ~^ hi) ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(0, 1000));
      x.w = ((pick == 2) ~^ hi) ? 12'($urandom_range(3000, 4095)) : 12'($urandom_range(0, 1000));
    end while (edge_seen(rotor_plan.phase, regs_now.rev, x) != want);
    return x;
  endfunction

  // Queues one sample set and tracks the planned rotor state; returns its crossing flag.
  function automatic logic stage_sample(sample_set_t x);
    commutation_t r;
    r = predict_sample(rotor_plan, regs_now, x);
    queued_samples.push_back(x);
    planned++;
    return r.commutate;
  endfunction

  // Feeds a well-formed edge pattern (optional quiet lead-in, two hits, then silence)
  // until a crossing is confirmed; blanked samples in between are noise.
  task automatic chase_crossing(int lead, int run_pct, int fixed_ticks);
    int                   k;
    logic                 crossed;
    logic [SC_BITS-1:0]   nxt;
    logic [TICK_BITS-1:0] ticks;
    logic                 run;
    k = 0;
    crossed = 1'b0;
    while (!crossed) begin
      nxt = (rotor_plan.samples == 8'hFF) ? 8'hFF : rotor_plan.samples + 8'd1;
      ticks = (fixed_ticks < 0) ? pick_ticks() : 16'(fixed_ticks);
      run = ($urandom_range(0, 99) < run_pct);
      if (nxt < regs_now.blank) begin
        crossed = stage_sample(noise_sample());
      end else begin
        crossed = stage_sample(shape_sample(k >= lead && k - lead < 2, ticks, run));
        k++;
      end
    end
  endtask

  // Waits until every transaction has completed, then lets the block settle.
  task automatic settle_block();
    do @(negedge clk);
    while (queued_samples.size() != 0 || awaited_results.size() != 0 ||
           samples_offered != samples_taken);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(cfg_idx_t idx, logic [DIV_BITS-1:0] word);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= word;
  endtask

  // Writes all registers; unused upper bits carry junk that the block must ignore.
  task automatic load_registers(logic [SC_BITS-1:0] blank, logic rev, logic [DIV_BITS-1:0] speed);
    logic [DIV_BITS-1:0] word;
    word = $urandom;
    word[SC_BITS-1:0] = blank;
    write_register(CFG_BLANKING, word);
    word = $urandom;
    word[0] = rev;
    write_register(CFG_REVERSE, word);
    write_register(CFG_SPEED, speed);
    regs_now = '{blank: blank, rev: rev, speed: speed};
    @(negedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // One configuration phase: settle, reprogram, then queue random traffic.
  task automatic run_stage(logic [SC_BITS-1:0] blank, logic rev, logic [DIV_BITS-1:0] speed,
                           int gap, int stall, bit press, int count, bit fast_only);
    int roll;
    settle_block();
    gap_pct = gap;
    stall_pct = stall;
    press_on = press;
    load_registers(blank, rev, speed);
    planned = 0;
    while (planned < count) begin
      roll = $urandom_range(0, 99);
      if (fast_only) begin
        chase_crossing(0, 100, -1);
      end else if (roll < 70) begin
        chase_crossing((roll < 50) ? 0 : $urandom_range(1, 5), 90, -1);
      end else if (roll < 85) begin
        repeat (4) void'(stage_sample(shape_sample(1'($urandom_range(0, 1)), pick_ticks(),
                                                   $urandom_range(0, 9) != 0)));
      end else begin
        repeat ($urandom_range(1, 4)) void'(stage_sample(noise_sample()));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_addr = CFG_BLANKING;
    cfg_wdata = '0;
    in_ch.valid = 1'b0;
    in_ch.u_sample = '0;
    in_ch.v_sample = '0;
    in_ch.w_sample = '0;
    in_ch.elapsed_ticks = '0;
    in_ch.running = 1'b0;
    out_ch.ready = 1'b0;
    regs_now = '{blank: BLANK_RST, rev: 1'b0, speed: SPEED_RST};
    rotor_model = rotor_after_reset();
    rotor_plan = rotor_after_reset();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part under reset register values: flat and extreme samples, then
    // crossings with zero ticks (speed of all ones), the delay trim boundary and max.
    void'(stage_sample('{u: 12'h000, v: 12'h000, w: 12'h000, ticks: 16'h0000, run: 1'b0}));
    void'(stage_sample('{u: 12'hFFF, v: 12'hFFF, w: 12'hFFF, ticks: 16'hFFFF, run: 1'b1}));
    void'(stage_sample('{u: 12'h000, v: 12'h000, w: 12'hFFF, ticks: 16'h0001, run: 1'b1}));
    chase_crossing(0, 100, 0);
    chase_crossing(0, 100, 200);
    chase_crossing(0, 100, 201);
    chase_crossing(0, 100, 202);
    chase_crossing(0, 0, 65535);

    // Random phases: zero blanking with steady fast crossings to reach stall shutdown,
    // then both directions, speed factor extremes, maximum blanking and back-pressure.
    run_stage(8'd0, 1'b0, 32'd4000000, 0, 0, 1'b0, 260, 1'b1);
    run_stage(8'd3, 1'b1, 32'hFFFF_FFFF, 54, 0, 1'b0, 200, 1'b0);
    run_stage(8'd1, 1'b0, 32'd0, 0, 54, 1'b0, 200, 1'b0);
    run_stage(8'd255, 1'b1, $urandom, 15, 15, 1'b0, 280, 1'b0);
    run_stage(8'($urandom_range(2, 20)), 1'b0, $urandom, 0, 0, 1'b1, 150, 1'b0);
    run_stage(8'd2, 1'b1, $urandom, 15, 15, 1'b0, 120, 1'b0);
    settle_block();

    if (mismatches == 0) begin
      $display("[bemf_zero_cross_commutator_top] OK");
    end else begin
      $display("[bemf_zero_cross_commutator_top] ERROR");
    end
    $finish;
  end

endmodule
